/* sv/cbs_pkg.sv */
// Shared types, constants and helper functions for the centered binomial sampler.
package cbs_pkg;

	// Coefficients in one polynomial; the position counter wraps after this many.
	localparam int COEFFS_PER_POLY = 256;
	localparam int CNT_W           = $clog2(COEFFS_PER_POLY);
	localparam int IDX_W           = 8;

	// Bit store geometry.
	localparam int STORE_W = 25;
	localparam int HELD_W  = 5;
	localparam int BYTE_W  = 8;

	// Eta register and its limits.
	localparam int          ETA_W     = 4;
	localparam logic [3:0]  ETA_RESET = 4'd2;
	localparam logic [3:0]  ETA_MIN   = 4'd1;
	localparam logic [3:0]  ETA_MAX   = 4'd9;

	// Widest half run, and the most coefficients one byte can cause.
	localparam int HALF_W    = 9;
	localparam int POP_W     = 4;
	localparam int COEFF_W   = 5;
	localparam int MAX_COEFF = 4;
	localparam int NUM_W     = 3;

	// Job queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One unit of work for the back end: a window of stream bits and how many
	// coefficients to cut from it.
	typedef struct packed {
		logic [STORE_W-1:0] window;
		logic [NUM_W-1:0]   num;
		logic [ETA_W-1:0]   eta;
	} cbs_job_t;

	// Map any register value onto the supported range.
	function automatic logic [ETA_W-1:0] clamp_eta(input logic [ETA_W-1:0] v);
		logic [ETA_W-1:0] r;
		r = v;
		if (v < ETA_MIN) begin
			r = ETA_MIN;
		end else if (v > ETA_MAX) begin
			r = ETA_MAX;
		end
		return r;
	endfunction

	// Mask of the low eta bits of a half run.
	function automatic logic [HALF_W-1:0] half_mask(input logic [ETA_W-1:0] e);
		logic [HALF_W:0] m;
		m = ((HALF_W+1)'(1) << e) - (HALF_W+1)'(1);
		return m[HALF_W-1:0];
	endfunction

	// Number of set bits in a half run.
	function automatic logic [POP_W-1:0] pop_half(input logic [HALF_W-1:0] v);
		logic [POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < HALF_W; i++) begin
			n = n + POP_W'(v[i]);
		end
		return n;
	endfunction

endpackage

/* sv/centered_binomial_sampler.sv */
// Top level of the centered binomial sampler: front end, job queue and back end.
//
//   channel   direction  handshake                 payload
//   input     in         push / full               random_byte
//   result    out        pop / empty               coefficient, coeff_index,
//                                                  run_last, poly_done
//   config    in         cfg_valid / cfg_ready     eta
//
// A byte is taken every cycle while the job queue has room; the back end
// emits one coefficient per cycle while the result side takes them. A byte
// yields four coefficients with eta 1, two with eta 2, one or two with eta 3,
// one with eta 4 and at most one above that. Reset clears eta to 2, the
// bit store and the position counter.
// A stalled result side fills the output register, then the two-job queue,
// then raises full. cfg_ready is always high; a write drops the held bits.
module centered_binomial_sampler (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        random_byte,
	output logic              empty,
	input  logic              pop,
	output logic signed [4:0] coefficient,
	output logic [7:0]        coeff_index,
	output logic              run_last,
	output logic              poly_done,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        eta
);
	import cbs_pkg::*;

	cbs_job_t push_job;
	cbs_job_t head_job;
	logic     job_push;
	logic     job_take;
	logic     q_full;
	logic     q_empty;

	assign cfg_ready = 1'b1;

	// Byte intake and run counting.
	cbs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.random_byte (random_byte),
		.cfg_valid   (cfg_valid),
		.eta         (eta),
		.queue_full  (q_full),
		.full        (full),
		.job_push    (job_push),
		.job         (push_job)
	);

	// Decoupling queue.
	cbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_push),
		.wr_job   (push_job),
		.rd_en    (job_take),
		.rd_job   (head_job),
		.is_full  (q_full),
		.is_empty (q_empty)
	);

	// Coefficient generation and result register.
	cbs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (head_job),
		.job_avail   (!q_empty),
		.job_take    (job_take),
		.pop         (pop),
		.empty       (empty),
		.coefficient (coefficient),
		.coeff_index (coeff_index),
		.run_last    (run_last),
		.poly_done   (poly_done)
	);

endmodule

/* sv/cbs_front.sv */
// Front end: takes random bytes, keeps leftover bits and hands whole runs to the queue.
module cbs_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [7:0]               random_byte,
	input  logic                     cfg_valid,
	input  logic [3:0]               eta,
	input  logic                     queue_full,
	output logic                     full,
	output logic                     job_push,
	output cbs_pkg::cbs_job_t        job
);
	import cbs_pkg::*;

	logic [ETA_W-1:0]   eta_q;
	logic [STORE_W-1:0] store_q;
	logic [HELD_W-1:0]  held_q;

	logic [HELD_W-1:0]  run;
	logic [HELD_W-1:0]  total;
	logic [STORE_W-1:0] combined;
	logic [6:0]         run1, run2, run3, run4, used;
	logic [NUM_W-1:0]   num;
	logic               accept;

	// The queue is the only thing that holds the front back.
	assign full   = queue_full;
	assign accept = push && !full;

	// Append the byte above the held bits.
	assign run      = HELD_W'({eta_q, 1'b0});
	assign total    = held_q + HELD_W'(BYTE_W);
	assign combined = store_q | (STORE_W'(random_byte) << held_q);

	// Count whole runs present, at most four.
	assign run1 = 7'(run);
	assign run2 = 7'(run) << 1;
	assign run3 = 7'(run) + (7'(run) << 1);
	assign run4 = 7'(run) << 2;

	always_comb begin
		num = '0;
		if (run4 <= 7'(total)) begin
			num = NUM_W'(4);
		end else if (run3 <= 7'(total)) begin
			num = NUM_W'(3);
		end else if (run2 <= 7'(total)) begin
			num = NUM_W'(2);
		end else if (run1 <= 7'(total)) begin
			num = NUM_W'(1);
		end
	end

	// Bits consumed by this byte's coefficients.
	always_comb begin
		case (num)
			NUM_W'(1): used = run1;
			NUM_W'(2): used = run2;
			NUM_W'(3): used = run3;
			NUM_W'(4): used = run4;
			default:   used = '0;
		endcase
	end

	// Only bytes that complete a run create a job.
	assign job_push   = accept && (num != '0);
	assign job.window = combined;
	assign job.num    = num;
	assign job.eta    = eta_q;

	// Eta register and bit store; a register write drops the held bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_q   <= ETA_RESET;
			store_q <= '0;
			held_q  <= '0;
		end else if (cfg_valid) begin
			eta_q   <= clamp_eta(eta);
			store_q <= '0;
			held_q  <= '0;
		end else if (accept) begin
			store_q <= combined >> used;
			held_q  <= total - HELD_W'(used);
		end
	end

endmodule

/* sv/cbs_queue.sv */
// Short job queue that decouples the front end from the back end.
module cbs_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  cbs_pkg::cbs_job_t        wr_job,
	input  logic                     rd_en,
	output cbs_pkg::cbs_job_t        rd_job,
	output logic                     is_full,
	output logic                     is_empty
);
	import cbs_pkg::*;

	cbs_job_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign is_full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign is_empty = (cnt_q == '0);
	assign rd_job   = slot_q[rd_ptr_q];

	// Pointer step with wrap at the depth.
	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
		return r;
	endfunction

	// Storage slots.
	always_ff @(posedge clk) begin
		if (wr_en && !is_full) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en && !is_full) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en && !is_empty) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if ((wr_en && !is_full) && !(rd_en && !is_empty)) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!(wr_en && !is_full) && (rd_en && !is_empty)) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

/* sv/cbs_back.sv */
// Back end: cuts one coefficient per cycle from a job while the output register is free, and holds it there.
module cbs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cbs_pkg::cbs_job_t             job,
	input  logic                          job_avail,
	output logic                          job_take,
	input  logic                          pop,
	output logic                          empty,
	output logic signed [4:0]             coefficient,
	output logic [7:0]                    coeff_index,
	output logic                          run_last,
	output logic                          poly_done
);
	import cbs_pkg::*;

	logic [STORE_W-1:0] win_q;
	logic [NUM_W-1:0]   left_q;
	logic [ETA_W-1:0]   eta_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               out_valid_q;
	logic [COEFF_W-1:0] coeff_q;
	logic [IDX_W-1:0]   idx_q;
	logic               last_q;
	logic               done_q;

	logic               busy;
	logic               advance;
	logic               emit;
	logic [HALF_W-1:0]  mask;
	logic [POP_W-1:0]   lo_cnt, hi_cnt;
	logic               at_end;
	logic [IDX_W+CNT_W-1:0] idx_ext;

	// The output register frees when it is empty or being taken this cycle.
	assign busy     = (left_q != '0);
	assign advance  = !out_valid_q || pop;
	assign emit     = busy && advance;
	assign job_take = job_avail && (!busy || (emit && left_q == NUM_W'(1)));

	// Coefficient of the oldest run in the window.
	assign mask   = half_mask(eta_q);
	assign lo_cnt = pop_half(win_q[HALF_W-1:0] & mask);
	assign hi_cnt = pop_half(HALF_W'(win_q >> eta_q) & mask);

	assign at_end  = (cnt_q == CNT_W'(COEFFS_PER_POLY - 1));
	assign idx_ext = {{IDX_W{1'b0}}, cnt_q};

	// Current job: window, coefficients left, eta.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (job_take) begin
			left_q <= job.num;
		end else if (emit) begin
			left_q <= left_q - NUM_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			win_q <= job.window;
			eta_q <= job.eta;
		end else if (emit) begin
			win_q <= win_q >> {eta_q, 1'b0};
		end
	end

	// Position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (emit) begin
			cnt_q <= at_end ? '0 : cnt_q + CNT_W'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			coeff_q <= COEFF_W'(lo_cnt) - COEFF_W'(hi_cnt);
			idx_q   <= idx_ext[IDX_W-1:0];
			last_q  <= (left_q == NUM_W'(1));
			done_q  <= at_end;
		end
	end

	assign empty       = !out_valid_q;
	assign coefficient = coeff_q;
	assign coeff_index = idx_q;
	assign run_last    = last_q;
	assign poly_done   = done_q;

endmodule

/* sv/cbs_checker.sv */
// Port-level checks for the centered binomial sampler, bound to the top level.
module cbs_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  logic              pop,
	input  logic signed [4:0] coefficient,
	input  logic [7:0]        coeff_index,
	input  logic              run_last,
	input  logic              poly_done
);
	import cbs_pkg::*;

	localparam logic [CNT_W+IDX_W-1:0] LAST_POS = (CNT_W+IDX_W)'(COEFFS_PER_POLY - 1);

	// A waiting result beat holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(coefficient) && $stable(coeff_index)
			&& $stable(run_last) && $stable(poly_done)))
		else $error("result beat changed while stalled");

	// Coefficients stay within plus or minus nine.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (coefficient >= -5'sd9 && coefficient <= 5'sd9))
		else $error("coefficient out of range");

	// The polynomial completes only at the last position.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && poly_done) |-> (coeff_index == LAST_POS[IDX_W-1:0]))
		else $error("poly_done at wrong position");

	// After a beat is taken, the next beat shown carries the following position.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !poly_done) ##1 !empty
			|-> (coeff_index == $past(coeff_index) + 8'd1))
		else $error("coefficient positions not consecutive");

	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && poly_done) ##1 !empty |-> (coeff_index == 8'd0))
		else $error("position did not wrap after a full polynomial");

endmodule

bind centered_binomial_sampler cbs_checker u_cbs_checker (.*);
